### src/hpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared constants and types for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	// Three reduced products plus one row-3 entry, summed without loss.
	localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
	// Partial remainder width of the divider cells.
	localparam int REM_W     = SUM_W + DATA_W;
	localparam int ENTRIES   = 16;
	localparam int IDX_W     = $clog2(ENTRIES);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_XFORM = 1'b1;

	localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic vld;
		logic neg;
		logic ovf;
		logic wz;
	} hpt_ctl_t;

	function automatic logic [DATA_W-1:0] ident_entry(input int idx);
		logic [DATA_W-1:0] one;
		one = DATA_W'(1) << FRAC_BITS;
		return ((idx % 5) == 0) ? one : '0;
	endfunction

endpackage

### src/hpt_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_div_cell
// One restoring division step: decides one quotient bit per cycle while en is high.
// ----------------------------------------------------------------------------
module hpt_div_cell
	import hpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  hpt_ctl_t          ctl_in,
	input  logic [REM_W-1:0]  rem_in,
	input  logic [REM_W-1:0]  dvs_in,
	input  logic [DATA_W-1:0] quo_in,
	output hpt_ctl_t          ctl_q,
	output logic [REM_W-1:0]  rem_q,
	output logic [REM_W-1:0]  dvs_q,
	output logic [DATA_W-1:0] quo_q
);

	logic             ge;
	logic [REM_W-1:0] nxt;

	always_comb begin
		ge  = rem_in >= dvs_in;
		nxt = ge ? (rem_in - dvs_in) : rem_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// The remainder stays below the divisor after the step, so its top bit is free.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= {nxt[REM_W-2:0], 1'b0};
			dvs_q <= dvs_in;
			quo_q <= {quo_in[DATA_W-2:0], ge};
		end
	end

endmodule

### src/hpt_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_divider
// Signed fixed-point divide (num << FRAC_BITS) / den with saturation; den == 0 gives zero and sets wz.
// ----------------------------------------------------------------------------
module hpt_divider
	import hpt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld,
	input  logic signed [SUM_W-1:0] num,
	input  logic signed [SUM_W-1:0] den,
	output logic                    res_vld,
	output logic [DATA_W-1:0]       quo,
	output logic                    sat,
	output logic                    wz
);

	logic [SUM_W-1:0] a_mag;
	logic [SUM_W-1:0] b_mag;
	hpt_ctl_t         ctl_p_q;
	logic [REM_W-1:0] rem_p_q;
	logic [REM_W-1:0] dvs_p_q;
	hpt_ctl_t         ctl_c_q;
	logic [REM_W-1:0] rem_c_q;
	logic [REM_W-1:0] dvs_c_q;

	hpt_ctl_t          ctl_w [0:DATA_W];
	logic [REM_W-1:0]  rem_w [0:DATA_W];
	logic [REM_W-1:0]  dvs_w [0:DATA_W];
	logic [DATA_W-1:0] quo_w [0:DATA_W];

	always_comb begin
		a_mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
		b_mag = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_p_q <= '0;
			ctl_c_q <= '0;
		end else if (en) begin
			ctl_p_q <= '{vld: vld, neg: num[SUM_W-1] ^ den[SUM_W-1], ovf: 1'b0,
				wz: den == '0};
			// A quotient of 2^32 or more can never fit.
			ctl_c_q <= '{vld: ctl_p_q.vld, neg: ctl_p_q.neg,
				ovf: {1'b0, rem_p_q} >= {dvs_p_q, 1'b0}, wz: ctl_p_q.wz};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_p_q <= {{(DATA_W-FRAC_BITS){1'b0}}, a_mag, {FRAC_BITS{1'b0}}};
			dvs_p_q <= {1'b0, b_mag, {(DATA_W-1){1'b0}}};
			rem_c_q <= rem_p_q;
			dvs_c_q <= dvs_p_q;
		end
	end

	assign ctl_w[0] = ctl_c_q;
	assign rem_w[0] = rem_c_q;
	assign dvs_w[0] = dvs_c_q;
	assign quo_w[0] = '0;

	for (genvar i = 0; i < DATA_W; i++) begin : g_cell
		hpt_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_w[i]),
			.rem_in (rem_w[i]),
			.dvs_in (dvs_w[i]),
			.quo_in (quo_w[i]),
			.ctl_q  (ctl_w[i+1]),
			.rem_q  (rem_w[i+1]),
			.dvs_q  (dvs_w[i+1]),
			.quo_q  (quo_w[i+1])
		);
	end

	always_comb begin
		res_vld = ctl_w[DATA_W].vld;
		wz      = ctl_w[DATA_W].wz;
		sat     = 1'b0;
		quo     = '0;
		if (ctl_w[DATA_W].wz) begin
			quo = '0;
		end else if (ctl_w[DATA_W].neg) begin
			if (ctl_w[DATA_W].ovf || quo_w[DATA_W] > NEG_MAX) begin
				sat = 1'b1;
				quo = NEG_MAX;
			end else begin
				quo = DATA_W'(-quo_w[DATA_W]);
			end
		end else begin
			if (ctl_w[DATA_W].ovf || quo_w[DATA_W][DATA_W-1]) begin
				sat = 1'b1;
				quo = POS_MAX;
			end else begin
				quo = quo_w[DATA_W];
			end
		end
	end

endmodule

### src/homogeneous_point_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous point transform with perspective divide, signed Q16.16.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while item_stall is low, and
// returns one result word per transform word, in order. A load word writes
// one entry of the 4x4 matrix at once and returns nothing; a transform word
// that follows it already sees the new entry. The matrix resets to identity.
// A transform word goes through the products (one 32x32 multiplier per matrix
// entry of rows 0 to 2), the column sums, and then three dividers, each a
// chain of 32 cells that decide one quotient bit per cycle; that chain sets
// the latency, and the rate stays one word per cycle. The whole pipeline
// holds while a result waits under result_stall, so item_stall follows
// result_stall in the same cycle. When w is zero, the outputs are zero and
// w_zero is set; a quotient that leaves the 32-bit range clips and sets
// saturated.
// ----------------------------------------------------------------------------
module homogeneous_point_transform
	import hpt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     op,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	input  logic signed [DATA_W-1:0] point_x,
	input  logic signed [DATA_W-1:0] point_y,
	input  logic signed [DATA_W-1:0] point_z,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic                     w_zero,
	output logic                     saturated
);

	logic                     en;
	logic                     acc;
	logic [DATA_W-1:0]        mat_q [0:ENTRIES-1];
	logic signed [DATA_W-1:0] pt [0:2];

	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s1 [0:2][0:3];
	logic signed [DATA_W-1:0] row3_s1 [0:3];
	logic                     vld_s2;
	logic signed [SUM_W-1:0]  sum_s2 [0:3];

	logic                     dv_vld [0:2];
	logic [DATA_W-1:0]        dv_quo [0:2];
	logic                     dv_sat [0:2];
	logic                     dv_wz  [0:2];

	// The pipeline moves whenever the output register is free or being taken.
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;
	assign acc        = item_valid && en;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// Matrix entries, written by load words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				mat_q[i] <= ident_entry(i);
			end
		end else if (acc && op == OP_LOAD) begin
			mat_q[entry_index] <= entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc && op == OP_XFORM;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: every product of a point coordinate with its matrix entry, and a copy of row 3.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= PROD_W'(pt[r]) * PROD_W'($signed(mat_q[r*4+c]));
				end
			end
			for (int c = 0; c < 4; c++) begin
				row3_s1[c] <= $signed(mat_q[12+c]);
			end
		end
	end

	// Stage 2: column sums of the floored products; column 3 is w.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				sum_s2[c] <= SUM_W'(prod_s1[0][c] >>> FRAC_BITS)
					+ SUM_W'(prod_s1[1][c] >>> FRAC_BITS)
					+ SUM_W'(prod_s1[2][c] >>> FRAC_BITS)
					+ SUM_W'(row3_s1[c]);
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		hpt_divider u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld     (vld_s2),
			.num     (sum_s2[k]),
			.den     (sum_s2[3]),
			.res_vld (dv_vld[k]),
			.quo     (dv_quo[k]),
			.sat     (dv_sat[k]),
			.wz      (dv_wz[k])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= dv_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x     <= dv_quo[0];
			out_y     <= dv_quo[1];
			out_z     <= dv_quo[2];
			w_zero    <= dv_wz[0];
			saturated <= !dv_wz[0] && (dv_sat[0] || dv_sat[1] || dv_sat[2]);
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input held without a waiting result");

	a_wzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && w_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !saturated)
		else $error("zero w result carries data");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			out_x == POS_MAX || out_x == NEG_MAX || out_y == POS_MAX ||
			out_y == NEG_MAX || out_z == POS_MAX || out_z == NEG_MAX)
		else $error("saturated flag without a clipped coordinate");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && op == OP_LOAD |=>
			mat_q[$past(entry_index)] == $past(entry_value))
		else $error("matrix entry not written");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the homogeneous point transform.
// ----------------------------------------------------------------------------
// Matrix loads and point transforms are sent under random bursts and gaps
// while the result side stalls on changing patterns. An in-bench copy of the
// matrix predicts each transformed point at the moment its word is taken,
// and results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb;
	import hpt_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic                     wz;
		logic                     sat;
	} point_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     item_valid;
	logic                     item_stall;
	logic                     op;
	logic [IDX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;
	logic signed [DATA_W-1:0] point_z;
	logic                     result_valid;
	logic                     result_stall;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;
	logic                     w_zero;
	logic                     saturated;

	// Matrix copy used for prediction, and the points still owed by the block.
	logic signed [DATA_W-1:0] matrix_copy [ENTRIES];
	point_result_t            pending_points[$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit          no_gaps;
	int unsigned hold_request;
	int unsigned stall_mode;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 60;

	homogeneous_point_transform DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.op(op), .entry_index(entry_index), .entry_value(entry_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.w_zero(w_zero), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Column sum d_c = x*M[0][c] + y*M[1][c] + z*M[2][c] + M[3][c], with each
	// product floored back to the fixed-point scale before summing.
	function automatic longint column_sum(input logic signed [DATA_W-1:0] px,
			input logic signed [DATA_W-1:0] py, input logic signed [DATA_W-1:0] pz,
			input int c);
		longint s;
		s = (longint'(px) * longint'(matrix_copy[c])) >>> FRAC_BITS;
		s += (longint'(py) * longint'(matrix_copy[4 + c])) >>> FRAC_BITS;
		s += (longint'(pz) * longint'(matrix_copy[8 + c])) >>> FRAC_BITS;
		s += longint'(matrix_copy[12 + c]);
		return s;
	endfunction

	// Quotient (d << FRAC_BITS) / w, truncated toward zero, clipped to 32 bits.
	function automatic logic signed [DATA_W-1:0] scaled_divide(input longint d,
			input longint w, inout logic sat);
		logic [127:0] num_mag;
		logic [127:0] den_mag;
		logic [127:0] quo;
		logic         neg;
		neg     = (d < 0) != (w < 0);
		num_mag = 128'(d < 0 ? -d : d);
		den_mag = 128'(w < 0 ? -w : w);
		quo     = (num_mag << FRAC_BITS) / den_mag;
		if (neg) begin
			if (quo > 128'h8000_0000) begin
				sat = 1'b1;
				return NEG_MAX;
			end
			return -quo[DATA_W-1:0];
		end
		if (quo > 128'h7FFF_FFFF) begin
			sat = 1'b1;
			return POS_MAX;
		end
		return quo[DATA_W-1:0];
	endfunction

	function automatic point_result_t project_point(input logic signed [DATA_W-1:0] px,
			input logic signed [DATA_W-1:0] py, input logic signed [DATA_W-1:0] pz);
		point_result_t r;
		longint        d0, d1, d2, w;
		logic          sat;
		d0  = column_sum(px, py, pz, 0);
		d1  = column_sum(px, py, pz, 1);
		d2  = column_sum(px, py, pz, 2);
		w   = column_sum(px, py, pz, 3);
		sat = 1'b0;
		if (w == 0) begin
			r.x = '0; r.y = '0; r.z = '0; r.wz = 1'b1; r.sat = 1'b0;
		end else begin
			r.x  = scaled_divide(d0, w, sat);
			r.y  = scaled_divide(d1, w, sat);
			r.z  = scaled_divide(d2, w, sat);
			r.wz = 1'b0;
			r.sat = sat;
		end
		return r;
	endfunction

	// Input monitor: every word taken updates the matrix copy or queues the
	// predicted point, in the same order the block sees them.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			if (op == OP_LOAD)
				matrix_copy[entry_index] <= entry_value;
			else
				pending_points.push_back(project_point(point_x, point_y, point_z));
		end
	end

	// Result checker.
	always @(posedge clk) begin
		point_result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x, out_y, out_z);
				error_count++;
			end else begin
				e = pending_points.pop_front();
				if (out_x !== e.x) begin
					$display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
					error_count++;
				end
				if (out_y !== e.y) begin
					$display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
					error_count++;
				end
				if (out_z !== e.z) begin
					$display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
					error_count++;
				end
				if (w_zero !== e.wz) begin
					$display("%0t: w_zero expected %b actual %b", $time, e.wz, w_zero);
					error_count++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
					error_count++;
				end
			end
		end
	end

	// Receiver: a long hold-off when one is requested, otherwise a stall
	// pattern that changes every so often (none, light, heavy, periodic).
	initial begin
		int unsigned hold_left;
		int unsigned phase;
		hold_left = 0;
		phase = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (phase % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 9) < 3);
					2: result_stall <= ($urandom_range(0, 9) < 7);
					default: result_stall <= (phase % 5) < 2;
				endcase
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Sends one word and returns at the edge where it was taken; at the end of a
	// burst, unless no_gaps is set, it first drops valid for a random gap.
	task automatic send_word(input logic o, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] val, input logic signed [DATA_W-1:0] px,
			input logic signed [DATA_W-1:0] py, input logic signed [DATA_W-1:0] pz);
		int unsigned gap;
		item_valid  <= 1'b1;
		op          <= o;
		entry_index <= idx;
		entry_value <= val;
		point_x     <= px;
		point_y     <= py;
		point_z     <= pz;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (!no_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	task automatic load_entry(input int idx, input logic signed [DATA_W-1:0] val);
		send_word(OP_LOAD, IDX_W'(idx), val, $urandom, $urandom, $urandom);
	endtask

	task automatic transform(input logic signed [DATA_W-1:0] px,
			input logic signed [DATA_W-1:0] py, input logic signed [DATA_W-1:0] pz);
		send_word(OP_XFORM, IDX_W'($urandom), $urandom, px, py, pz);
	endtask

	// Waits for all owed results and then for the pipeline to empty.
	task automatic drain;
		item_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_entry;
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 11)
			return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
		if (k < 13)
			return $urandom;
		if (k < 16)
			return '0;
		return DATA_W'(1) << FRAC_BITS;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_coord;
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		if (k < 9)
			return $urandom;
		return k[0] ? POS_MAX : NEG_MAX;
	endfunction

	task automatic reset_identity;
		for (int i = 0; i < ENTRIES; i++)
			load_entry(i, ident_entry(i));
	endtask

	// Extremes, the zero-w case, saturation in both directions, a negative w
	// and words whose unused fields carry noise.
	task automatic test_directed;
		transform(32'sh0001_8000, -32'sh0002_0000, 32'sh0000_0001);
		transform(POS_MAX, NEG_MAX, '0);
		transform(NEG_MAX, POS_MAX, 32'shFFFF_FFFF);
		load_entry(15, '0);
		transform(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
		load_entry(15, 32'sh0000_0001);
		transform(32'sh0100_0000, -32'sh0100_0000, 32'sh0000_0000);
		transform(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000);
		load_entry(15, -32'sh0002_0000);
		transform(32'sh0003_0000, -32'sh0005_0000, 32'sh0000_4000);
		load_entry(3, 32'sh0000_8000);
		load_entry(15, 32'sh0000_0000);
		transform(32'sh0002_0000, 32'sh0001_0000, POS_MAX);
		transform('0, '0, '0);
		load_entry(10, POS_MAX);
		load_entry(5, NEG_MAX);
		transform(POS_MAX, POS_MAX, POS_MAX);
		transform(NEG_MAX, NEG_MAX, NEG_MAX);
		drain();
		reset_identity();
	endtask

	task automatic test_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				load_entry($urandom_range(0, ENTRIES - 1), rand_entry());
			else
				transform(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// The receiver holds off for a long stretch while points keep coming, so
	// the pipeline fills and the input stalls.
	task automatic test_long_stall;
		no_gaps = 1'b1;
		hold_request = 300;
		for (int n = 0; n < 80; n++)
			transform(rand_coord(), rand_coord(), rand_coord());
		no_gaps = 1'b0;
	endtask

	// The sender pauses until everything owed has come back.
	task automatic test_drain_pause;
		test_random(40);
		drain();
		test_random(40);
	endtask

	initial begin
		error_count  = 0;
		cycle_count  = 0;
		burst_left   = 0;
		no_gaps      = 1'b0;
		hold_request = 0;
		stall_mode   = 0;
		for (int i = 0; i < ENTRIES; i++)
			matrix_copy[i] = ident_entry(i);
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		op          = OP_LOAD;
		entry_index = '0;
		entry_value = '0;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250);
		test_long_stall();
		test_drain_pause();
		test_random(220);

		drain();
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
